// ===== rtl/sdr_pkg.sv =====
// ----------------------------------------------------------------------------
// sunrise dimmer ramp package
// Shared types and constants for the controller, datapath and divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

  localparam int unsigned DIV_W     = 23;  // widest dividend: width*100
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned IVAL_W    = 18;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned RECIP_W   = 24;
  localparam int unsigned PROD_W    = DIV_W + RECIP_W;

  localparam logic [WIDTH_W-1:0] PERIOD_RESET = 16'd10000;
  localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
  localparam logic [IVAL_W-1:0]  IVAL_MAX     = 18'h3FFFF;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX    = 16'hFFFF;

  // divide by 100 as a multiply by a rounded-up reciprocal, exact below 2^DIV_W
  localparam int unsigned        PCT_SCALE   = 100;
  localparam int unsigned        LEVEL_SHIFT = DIV_W + $clog2(PCT_SCALE);
  localparam logic [RECIP_W-1:0] LEVEL_RECIP =
    RECIP_W'(((64'd1 << LEVEL_SHIFT) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE));

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_SET   = 2'd2,
    REQ_READ  = 2'd3
  } req_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OPDIV,
    ST_PCT,
    ST_PCTDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic op_finish;
    logic pct_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_e_t req;
    logic   op_done;
    logic   div_done;
    logic   out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/sdr_div.sv =====
// ----------------------------------------------------------------------------
// sunrise dimmer percent divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [sdr_pkg::DIV_W-1:0]        dividend,
  input  wire logic [sdr_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                  done,
  output logic [sdr_pkg::DIV_W-1:0]             quotient
);

  localparam int unsigned CNT_W = $clog2(sdr_pkg::DIV_W + 1);

  logic [sdr_pkg::DIVISOR_W-1:0] rem;
  logic [sdr_pkg::DIVISOR_W-1:0] dvs;
  logic [sdr_pkg::DIV_W-1:0]     quo;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic [sdr_pkg::DIVISOR_W:0]   trial;
  logic [sdr_pkg::DIVISOR_W+1:0] diff;
  logic                          borrow;

  assign trial  = {rem, quo[sdr_pkg::DIV_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, dvs};
  assign borrow = diff[sdr_pkg::DIVISOR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(sdr_pkg::DIV_W);
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so 16 bits hold it either way
      rem <= borrow ? trial[sdr_pkg::DIVISOR_W-1:0] : diff[sdr_pkg::DIVISOR_W-1:0];
      quo <= {quo[sdr_pkg::DIV_W-2:0], ~borrow};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/sdr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sunrise dimmer controller
// Sequences one item: apply, optional divide, percent divide, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire sdr_pkg::status_t status,
  output sdr_pkg::cmd_t         cmd,
  output logic                  in_stall
);

  sdr_pkg::state_t state;
  sdr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sdr_pkg::ST_IDLE: begin
        if (in_valid) state_next = sdr_pkg::ST_EXEC;
      end
      sdr_pkg::ST_EXEC: begin
        if (status.req == sdr_pkg::REQ_START || status.req == sdr_pkg::REQ_SET) begin
          state_next = sdr_pkg::ST_OPDIV;
        end else begin
          state_next = sdr_pkg::ST_PCT;
        end
      end
      sdr_pkg::ST_OPDIV: begin
        if (status.op_done) state_next = sdr_pkg::ST_PCT;
      end
      sdr_pkg::ST_PCT: begin
        state_next = sdr_pkg::ST_PCTDIV;
      end
      sdr_pkg::ST_PCTDIV: begin
        if (status.div_done) state_next = sdr_pkg::ST_OUT;
      end
      sdr_pkg::ST_OUT: begin
        if (!status.out_busy) state_next = sdr_pkg::ST_IDLE;
      end
      default: state_next = sdr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == sdr_pkg::ST_IDLE) && in_valid;
    cmd.exec      = (state == sdr_pkg::ST_EXEC);
    cmd.op_finish = (state == sdr_pkg::ST_OPDIV) && status.op_done;
    cmd.pct_start = (state == sdr_pkg::ST_PCT);
    cmd.out_load  = (state == sdr_pkg::ST_OUT) && !status.out_busy;
    in_stall      = (state != sdr_pkg::ST_IDLE);
  end

endmodule

`default_nettype wire

// ===== rtl/sdr_dpath.sv =====
// ----------------------------------------------------------------------------
// sunrise dimmer datapath
// Dimmer state, ramp countdown, operand selection and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_dpath #(
  parameter int unsigned RAMP_STEPS       = 100,
  parameter int unsigned TICKS_PER_MINUTE = 60000
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sdr_pkg::cmd_t                  cmd,
  output sdr_pkg::status_t                    status,
  input  wire logic [1:0]                     req_type,
  input  wire logic [7:0]                     alarm_minutes,
  input  wire logic [7:0]                     level_percent,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [sdr_pkg::WIDTH_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [sdr_pkg::WIDTH_W-1:0]         pwm_width,
  output logic [sdr_pkg::PCT_W-1:0]           brightness_percent,
  output logic                                ramp_active
);

  localparam int unsigned IvalPerMin = TICKS_PER_MINUTE / RAMP_STEPS;
  localparam int unsigned StepShift  = sdr_pkg::DIV_W + $clog2(RAMP_STEPS);
  localparam logic [sdr_pkg::RECIP_W-1:0] StepRecip =
    sdr_pkg::RECIP_W'(((64'd1 << StepShift) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS));

  sdr_pkg::req_e_t                req;
  logic [7:0]                     minutes;
  logic [7:0]                     pct;
  logic [sdr_pkg::WIDTH_W-1:0]    period;
  logic [sdr_pkg::WIDTH_W-1:0]    width;
  logic [sdr_pkg::WIDTH_W-1:0]    step;
  logic [sdr_pkg::IVAL_W-1:0]     reload;
  logic [sdr_pkg::IVAL_W-1:0]     countdown;
  logic                           running;

  logic [27:0]                    ival_prod;
  logic [sdr_pkg::IVAL_W-1:0]     ival_sat;
  logic [sdr_pkg::PCT_W-1:0]      pct_sat;
  logic [sdr_pkg::DIV_W-1:0]      level_prod;
  logic [sdr_pkg::WIDTH_W-1:0]    diff;
  logic                           below;
  logic [sdr_pkg::WIDTH_W:0]      width_sum;
  logic [sdr_pkg::WIDTH_W:0]      step_inc;
  logic                           div_start;
  logic [sdr_pkg::DIV_W-1:0]      div_dividend;
  logic [sdr_pkg::DIVISOR_W-1:0]  div_divisor;
  logic                           div_done;
  logic [sdr_pkg::DIV_W-1:0]      div_quot;
  logic [sdr_pkg::PCT_W-1:0]      pct_result;

  logic [sdr_pkg::DIV_W-1:0]      op_num;
  logic [sdr_pkg::PROD_W-1:0]     op_prod;
  logic                           op_go;
  logic                           op_ready;
  logic [sdr_pkg::RECIP_W-1:0]    op_recip;
  logic [sdr_pkg::PROD_W-1:0]     op_shifted;
  logic [sdr_pkg::WIDTH_W-1:0]    op_quot;

  sdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign ival_prod  = 28'(minutes) * 28'(IvalPerMin);
  assign ival_sat   = (ival_prod > 28'(sdr_pkg::IVAL_MAX)) ? sdr_pkg::IVAL_MAX
                                                           : ival_prod[sdr_pkg::IVAL_W-1:0];
  assign pct_sat    = (pct > 8'(sdr_pkg::PCT_FULL)) ? sdr_pkg::PCT_FULL
                                                    : pct[sdr_pkg::PCT_W-1:0];
  assign level_prod = sdr_pkg::DIV_W'(period) * sdr_pkg::DIV_W'(pct_sat);
  assign below      = (width < period);
  assign diff       = below ? (period - width) : '0;
  assign width_sum  = {1'b0, width} + {1'b0, step};

  // step and set level divide by a constant: reciprocal multiply, then shift
  assign op_recip   = (req == sdr_pkg::REQ_START) ? StepRecip : sdr_pkg::LEVEL_RECIP;
  assign op_shifted = (req == sdr_pkg::REQ_START) ? (op_prod >> StepShift)
                                                  : (op_prod >> sdr_pkg::LEVEL_SHIFT);
  assign op_quot    = op_shifted[sdr_pkg::WIDTH_W-1:0];
  assign step_inc   = {1'b0, op_quot} + (sdr_pkg::WIDTH_W+1)'(1);

  // the serial divider only computes the percent
  assign div_start    = cmd.pct_start;
  assign div_dividend = sdr_pkg::DIV_W'(width) * sdr_pkg::DIV_W'(sdr_pkg::PCT_FULL);
  assign div_divisor  = period;

  always_comb begin
    priority if (period == '0) begin
      pct_result = '0;
    end else if (!below) begin
      pct_result = sdr_pkg::PCT_FULL;
    end else begin
      pct_result = div_quot[sdr_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req     <= sdr_pkg::req_e_t'(req_type);
      minutes <= alarm_minutes;
      pct     <= level_percent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_go    <= 1'b0;
      op_ready <= 1'b0;
    end else begin
      op_go    <= cmd.exec && (req == sdr_pkg::REQ_START || req == sdr_pkg::REQ_SET);
      op_ready <= op_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      op_num <= (req == sdr_pkg::REQ_START) ? sdr_pkg::DIV_W'(diff) : level_prod;
    end
    if (op_go) begin
      op_prod <= sdr_pkg::PROD_W'(op_num) * sdr_pkg::PROD_W'(op_recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= sdr_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      period <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width     <= '0;
      step      <= '0;
      reload    <= '0;
      countdown <= '0;
      running   <= 1'b0;
    end else if (cmd.exec) begin
      unique case (req)
        sdr_pkg::REQ_TICK: begin
          if (running) begin
            if (countdown > sdr_pkg::IVAL_W'(1)) begin
              countdown <= countdown - sdr_pkg::IVAL_W'(1);
            end else begin
              countdown <= reload;
              // overshoot clamps at the period and ends the ramp
              if (width_sum >= {1'b0, period}) begin
                width   <= period;
                running <= 1'b0;
              end else begin
                width <= width_sum[sdr_pkg::WIDTH_W-1:0];
              end
            end
          end
        end
        sdr_pkg::REQ_START: begin
          reload    <= ival_sat;
          countdown <= ival_sat;
        end
        sdr_pkg::REQ_SET, sdr_pkg::REQ_READ: begin
        end
        default: begin
        end
      endcase
    end else if (cmd.op_finish) begin
      if (req == sdr_pkg::REQ_START) begin
        step    <= step_inc[sdr_pkg::WIDTH_W] ? sdr_pkg::WIDTH_MAX
                                              : step_inc[sdr_pkg::WIDTH_W-1:0];
        running <= below;
      end else begin
        width   <= op_quot;
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pwm_width          <= width;
      brightness_percent <= pct_result;
      ramp_active        <= running;
    end
  end

  assign status.req      = req;
  assign status.op_done  = op_ready;
  assign status.div_done = div_done;
  assign status.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

// ===== rtl/sunrise_dimmer_ramp.sv =====
// ----------------------------------------------------------------------------
// sunrise dimmer ramp
// Dimmer with PWM width output and a timed sunrise ramp.
// ----------------------------------------------------------------------------
// One item is handled at a time. The result of a tick or read item is loaded
// into the output register after the percent divide; a start-alarm or
// set-level item also passes through the reciprocal multiply first, so its
// result is loaded later. The next item can be accepted in the cycle after
// the load. The percent of every item is computed by the 23-iteration
// shift-subtract divider; the ramp step and the set level are divisions by a
// constant, done by a registered reciprocal multiply. A finished result sits
// in the output register, so the next item is accepted while it waits; that
// item's result is held back until the waiting one is taken. The period
// register may be written at any time the block holds no item.
// ----------------------------------------------------------------------------
`default_nettype none

module sunrise_dimmer_ramp #(
  parameter int unsigned RAMP_STEPS       = 100,
  parameter int unsigned TICKS_PER_MINUTE = 60000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  alarm_minutes,
  input  wire logic [7:0]  level_percent,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      pwm_width,
  output logic [6:0]       brightness_percent,
  output logic             ramp_active,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  sdr_pkg::cmd_t    cmd;
  sdr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  sdr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  sdr_dpath #(
    .RAMP_STEPS       (RAMP_STEPS),
    .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
  ) u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .req_type           (req_type),
    .alarm_minutes      (alarm_minutes),
    .level_percent      (level_percent),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .pwm_width          (pwm_width),
    .brightness_percent (brightness_percent),
    .ramp_active        (ramp_active)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// sunrise dimmer ramp testbench
// Sends tick, start-alarm, set-level and read items with random gaps and
// output stalls, tracks the dimmer state in a scoreboard and compares every
// result field against it, across several pwm period settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned RAMP_STEPS       = 100;
  localparam int unsigned TICKS_PER_MINUTE = 60000;
  localparam int unsigned PHASE_ITEMS      = 140;
  localparam int unsigned HOLD_CYCLES      = 400;
  localparam int unsigned END_SETTLE       = 120;
  localparam int unsigned LIMIT_CYCLES     = 1000000;

  typedef struct packed {
    logic [15:0] width;
    logic [6:0]  pct;
    logic        ramp;
  } light_state_t;

  class dimmer_scoreboard;
    logic [15:0]  period;
    logic [15:0]  width;
    logic [15:0]  step;
    logic [17:0]  reload;
    logic [17:0]  countdown;
    logic         running;
    light_state_t expected_q[$];
    int           errors;

    function new();
      period    = sdr_pkg::PERIOD_RESET;
      width     = '0;
      step      = '0;
      reload    = '0;
      countdown = '0;
      running   = 1'b0;
      errors    = 0;
    endfunction

    function void set_period(logic [15:0] value);
      period = value;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function logic [6:0] percent_now();
      int unsigned p;
      if (period == 16'd0) return 7'd0;
      p = (32'(width) * 100) / 32'(period);
      return (p > 32'(sdr_pkg::PCT_FULL)) ? sdr_pkg::PCT_FULL : p[6:0];
    endfunction

    function void note_item(sdr_pkg::req_e_t req, logic [7:0] minutes, logic [7:0] percent);
      int unsigned  raised;
      int unsigned  interval;
      int unsigned  diff;
      int unsigned  new_step;
      int unsigned  pct_sat;
      light_state_t next_state;
      case (req)
        sdr_pkg::REQ_TICK: begin
          if (running) begin
            if (countdown > 18'd1) begin
              countdown = countdown - 18'd1;
            end else begin
              countdown = reload;
              raised = 32'(width) + 32'(step);
              // clamp at the period and end the ramp
              if (raised >= 32'(period)) begin
                width   = period;
                running = 1'b0;
              end else begin
                width = raised[15:0];
              end
            end
          end
        end
        sdr_pkg::REQ_START: begin
          interval  = 32'(minutes) * (TICKS_PER_MINUTE / RAMP_STEPS);
          reload    = (interval > 32'(sdr_pkg::IVAL_MAX)) ? sdr_pkg::IVAL_MAX
                                                          : interval[17:0];
          countdown = reload;
          diff      = (width < period) ? 32'(period) - 32'(width) : 0;
          new_step  = diff / RAMP_STEPS + 1;
          step      = (new_step > 32'(sdr_pkg::WIDTH_MAX)) ? sdr_pkg::WIDTH_MAX
                                                           : new_step[15:0];
          running   = (width < period);
        end
        sdr_pkg::REQ_SET: begin
          pct_sat = (percent > 8'd100) ? 100 : 32'(percent);
          width   = 16'((32'(period) * pct_sat) / 100);
          running = 1'b0;
        end
        default: begin
        end
      endcase
      next_state.width = width;
      next_state.pct   = percent_now();
      next_state.ramp  = running;
      expected_q.push_back(next_state);
    endfunction

    function void check_result(logic [15:0] got_width, logic [6:0] got_pct, logic got_ramp);
      light_state_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: width %0d percent %0d ramp %0b",
                 $time, got_width, got_pct, got_ramp);
        return;
      end
      want = expected_q.pop_front();
      if (got_width !== want.width) begin
        errors++;
        $display("%0t: pwm_width expected %0d actual %0d", $time, want.width, got_width);
      end
      if (got_pct !== want.pct) begin
        errors++;
        $display("%0t: brightness_percent expected %0d actual %0d", $time, want.pct, got_pct);
      end
      if (got_ramp !== want.ramp) begin
        errors++;
        $display("%0t: ramp_active expected %0b actual %0b", $time, want.ramp, got_ramp);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [7:0]  alarm_minutes;
  logic [7:0]  level_percent;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] pwm_width;
  logic [6:0]  brightness_percent;
  logic        ramp_active;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  logic        full_rate;
  logic        hold_off_req;

  dimmer_scoreboard sb;

  sunrise_dimmer_ramp #(
    .RAMP_STEPS       (RAMP_STEPS),
    .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .req_type           (req_type),
    .alarm_minutes      (alarm_minutes),
    .level_percent      (level_percent),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .pwm_width          (pwm_width),
    .brightness_percent (brightness_percent),
    .ramp_active        (ramp_active),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (full_rate) return 0;
    if (roll < 45) return 0;
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_minutes();
    int roll;
    roll = $urandom_range(99);
    if (roll < 65) return 8'd0;
    if (roll < 85) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] random_percent();
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return 8'($urandom_range(100));
    if (roll < 75) return 8'($urandom_range(101, 255));
    return 8'($urandom_range(255));
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int stall_len;
    bit hold_done;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        hold_done = 1'b1;
      end else if (!full_rate) begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall = 1'b1;
          repeat (stall_len) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(pwm_width, brightness_percent, ramp_active);
    end
  end

  // starts and ends at a falling edge; valid stays high if the next item follows
  task automatic send_item(input sdr_pkg::req_e_t req, input logic [7:0] minutes,
                           input logic [7:0] percent);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    req_type      = req;
    alarm_minutes = minutes;
    level_percent = percent;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(req, minutes, percent);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_period(value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_item();
    int              roll;
    sdr_pkg::req_e_t req;
    roll = $urandom_range(99);
    if (roll < 55)      req = sdr_pkg::REQ_TICK;
    else if (roll < 70) req = sdr_pkg::REQ_START;
    else if (roll < 83) req = sdr_pkg::REQ_SET;
    else                req = sdr_pkg::REQ_READ;
    send_item(req, random_minutes(), random_percent());
  endtask

  // an optional set, then a start at a short interval followed by a burst of mostly ticks
  task automatic send_ramp_run(output int sent);
    int n;
    int roll;
    sent = 0;
    if ($urandom_range(1) == 1) begin
      send_item(sdr_pkg::REQ_SET, random_minutes(), random_percent());
      sent++;
    end
    send_item(sdr_pkg::REQ_START,
              ($urandom_range(9) == 0) ? 8'($urandom_range(1, 2)) : 8'd0,
              random_percent());
    sent++;
    n = $urandom_range(10, 120);
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 90)      send_item(sdr_pkg::REQ_TICK, random_minutes(), random_percent());
      else if (roll < 95) send_item(sdr_pkg::REQ_READ, random_minutes(), random_percent());
      else                send_item(sdr_pkg::REQ_START, 8'd0, random_percent());
      sent++;
    end
  endtask

  task automatic run_random_phase(input int goal);
    int count;
    int got;
    int k;
    count = 0;
    while (count < goal) begin
      full_rate = ($urandom_range(4) == 0);
      if ($urandom_range(1) == 0) begin
        send_ramp_run(got);
        count += got;
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) send_random_item();
        count += k;
      end
    end
    full_rate = 1'b0;
  endtask

  // output held off while items keep coming, then the sender waits for all results
  task automatic fill_while_held();
    hold_off_req = 1'b1;
    full_rate    = 1'b1;
    repeat (24) send_random_item();
    full_rate = 1'b0;
    wait_drain();
  endtask

  initial begin : stimulus
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    req_type      = sdr_pkg::REQ_READ;
    alarm_minutes = 8'd0;
    level_percent = 8'd0;
    cfg_valid     = 1'b0;
    cfg_data      = 16'd0;
    full_rate     = 1'b0;
    hold_off_req  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(sdr_pkg::REQ_READ, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_TICK, 8'hFF, 8'hFF);    // idle tick
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd255);     // saturates to full
    send_item(sdr_pkg::REQ_START, 8'd1, 8'd0);     // already at period, ramp stays off
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd50);
    send_item(sdr_pkg::REQ_START, 8'd0, 8'd0);     // zero interval steps on every tick
    send_item(sdr_pkg::REQ_TICK, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_TICK, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_START, 8'd255, 8'd0);   // restart mid-ramp, longest interval
    send_item(sdr_pkg::REQ_TICK, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_READ, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_START, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_TICK, 8'd0, 8'd0);
    write_period(16'd50);                          // next step overshoots the new period
    send_item(sdr_pkg::REQ_TICK, 8'd0, 8'd0);
    write_period(16'hFFFF);
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd100);
    send_item(sdr_pkg::REQ_START, 8'd0, 8'd0);
    write_period(16'd3);                           // width now above period
    send_item(sdr_pkg::REQ_READ, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_START, 8'd0, 8'd0);
    write_period(16'd0);
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd40);
    send_item(sdr_pkg::REQ_START, 8'd0, 8'd0);
    send_item(sdr_pkg::REQ_READ, 8'd0, 8'd0);
    write_period(16'd1);
    send_item(sdr_pkg::REQ_SET, 8'd0, 8'd100);

    write_period(sdr_pkg::PERIOD_RESET);
    run_random_phase(PHASE_ITEMS);
    write_period(16'd1);
    run_random_phase(PHASE_ITEMS);
    write_period(16'hFFFF);
    run_random_phase(PHASE_ITEMS);
    fill_while_held();
    write_period(16'd100);
    run_random_phase(PHASE_ITEMS);
    write_period(16'($urandom_range(2, 300)));
    run_random_phase(PHASE_ITEMS);
    write_period(16'($urandom_range(1, 65535)));
    run_random_phase(PHASE_ITEMS);
    write_period(16'($urandom_range(2, 1000)));
    run_random_phase(PHASE_ITEMS);

    wait_drain();
    repeat (END_SETTLE) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
